// File: hw/rtl/fpdf_pkg.sv
// Shared types and constants for the fixed-point decimal formatter.
// No dependencies; every other file imports this package.
package fpdf_pkg;

  localparam int NumDigits = 5;
  localparam int NumStages = 4;
  localparam int MaxChars  = 7;

  // Register indexes (word address bits [3:2])
  localparam logic [1:0] RegShowSign     = 2'd0;
  localparam logic [1:0] RegPointPosition = 2'd1;
  localparam logic [1:0] RegMinDigits    = 2'd2;

  localparam logic [2:0] MaxPoint     = 3'd4;
  localparam logic [3:0] MaxMinDigits = 4'd5;

  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharMinus = 7'h2D;
  localparam logic [6:0] CharPlus  = 7'h2B;
  localparam logic [6:0] CharPoint = 7'h2E;

  // Multiples 1..9 of the decimal weight handled by each digit stage
  localparam logic [16:0] DigitMult [NumStages][9] = '{
    '{17'd10000, 17'd20000, 17'd30000, 17'd40000, 17'd50000,
      17'd60000, 17'd70000, 17'd80000, 17'd90000},
    '{17'd1000, 17'd2000, 17'd3000, 17'd4000, 17'd5000,
      17'd6000, 17'd7000, 17'd8000, 17'd9000},
    '{17'd100, 17'd200, 17'd300, 17'd400, 17'd500,
      17'd600, 17'd700, 17'd800, 17'd900},
    '{17'd10, 17'd20, 17'd30, 17'd40, 17'd50,
      17'd60, 17'd70, 17'd80, 17'd90}
  };

  typedef struct packed {
    logic       show_sign;
    logic [2:0] point_position;
    logic [3:0] min_digits;
  } fpdf_cfg_t;

  typedef struct packed {
    logic                      neg;
    logic                      show_sign;
    logic [2:0]                num_digits;
    logic [2:0]                point;
    logic [15:0]               rem;
    logic [NumStages-1:0][3:0] digs;
  } fpdf_item_t;

endpackage

// File: hw/rtl/fpdf_cfg.sv
// APB register file for the formatter settings.
// Depends on fpdf_pkg.
module fpdf_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output fpdf_pkg::fpdf_cfg_t cfg_o
);
  import fpdf_pkg::*;

  fpdf_cfg_t  cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegShowSign:      cfg_d.show_sign      = pwdata[0];
        RegPointPosition: cfg_d.point_position = pwdata[2:0];
        RegMinDigits:     cfg_d.min_digits     = pwdata[3:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.show_sign      <= 1'b0;
      cfg_q.point_position <= 3'd0;
      cfg_q.min_digits     <= 4'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      RegShowSign:      prdata = {31'd0, cfg_q.show_sign};
      RegPointPosition: prdata = {29'd0, cfg_q.point_position};
      RegMinDigits:     prdata = {28'd0, cfg_q.min_digits};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/fpdf_front.sv
// First pipeline stage: magnitude, sign and digit count of the request.
// Depends on fpdf_pkg.
module fpdf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fpdf_pkg::fpdf_cfg_t  cfg_i,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic signed [15:0]   value_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output fpdf_pkg::fpdf_item_t item_o
);
  import fpdf_pkg::*;

  logic       valid_q;
  fpdf_item_t item_q, item_d;
  logic       neg;
  logic [15:0] mag;
  logic [2:0] own, mind, pt, n;

  assign neg = value_i[15];
  // -32768 wraps to 0x8000, which reads as 32768 unsigned
  assign mag = neg ? 16'(~value_i + 16'sd1) : value_i;

  always_comb begin
    if (mag >= 16'd10000)     own = 3'd5;
    else if (mag >= 16'd1000) own = 3'd4;
    else if (mag >= 16'd100)  own = 3'd3;
    else if (mag >= 16'd10)   own = 3'd2;
    else                      own = 3'd1;

    mind = (cfg_i.min_digits > MaxMinDigits) ? MaxMinDigits[2:0] : cfg_i.min_digits[2:0];
    pt   = (cfg_i.point_position > MaxPoint) ? MaxPoint : cfg_i.point_position;

    n = own;
    if (mind > n) n = mind;
    if (pt != 3'd0 && (pt + 3'd1) > n) n = pt + 3'd1;

    item_d.neg        = neg;
    item_d.show_sign  = cfg_i.show_sign;
    item_d.num_digits = n;
    item_d.point      = pt;
    item_d.rem        = mag;
    item_d.digs       = '0;
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: hw/rtl/fpdf_digit.sv
// One digit-extraction pipeline stage: splits off the digit of one decimal weight.
// Depends on fpdf_pkg (weight multiples table, item type).
module fpdf_digit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           stage_i,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  fpdf_pkg::fpdf_item_t item_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output fpdf_pkg::fpdf_item_t item_o
);
  import fpdf_pkg::*;

  logic        valid_q;
  fpdf_item_t  item_q, item_d;
  logic [3:0]  digit;
  logic [16:0] sub;

  // Compare against every multiple at once; the largest hit wins
  always_comb begin
    digit = 4'd0;
    sub   = 17'd0;
    for (int k = 0; k < 9; k++) begin
      if ({1'b0, item_i.rem} >= DigitMult[stage_i][k]) begin
        digit = 4'(k + 1);
        sub   = DigitMult[stage_i][k];
      end
    end
    item_d      = item_i;
    item_d.rem  = 16'({1'b0, item_i.rem} - sub);
    item_d.digs = {item_i.digs[NumStages-2:0], digit};
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: hw/rtl/fpdf_serial.sv
// Output stage: packs sign, digits and point into characters and shifts them out.
// Depends on fpdf_pkg.
module fpdf_serial (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  fpdf_pkg::fpdf_item_t item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [6:0]           character_o,
  output logic                 last_o
);
  import fpdf_pkg::*;

  logic [6:0] chr_q [MaxChars];
  logic [6:0] chr_d [MaxChars];
  logic [6:0] packed_chr [MaxChars];
  logic [3:0] dl [NumDigits];
  logic [2:0] left_q, left_d;
  logic [2:0] cnt;
  logic       take, busy, finishing;

  always_comb begin
    for (int i = 0; i < NumStages; i++) begin
      dl[i] = item_i.digs[NumStages-1-i];
    end
    dl[NumDigits-1] = item_i.rem[3:0];
  end

  // Build the character string; the point sits before the last pt digits
  always_comb begin
    cnt = 3'd0;
    for (int j = 0; j < MaxChars; j++) begin
      packed_chr[j] = CharZero;
    end
    if (item_i.show_sign) begin
      packed_chr[cnt] = item_i.neg ? CharMinus : CharPlus;
      cnt = cnt + 3'd1;
    end
    for (int i = 0; i < NumDigits; i++) begin
      if (3'(i) >= 3'(NumDigits) - item_i.num_digits) begin
        if (item_i.point != 3'd0 && 3'(i) == 3'(NumDigits) - item_i.point) begin
          packed_chr[cnt] = CharPoint;
          cnt = cnt + 3'd1;
        end
        packed_chr[cnt] = CharZero + {3'b000, dl[i]};
        cnt = cnt + 3'd1;
      end
    end
  end

  assign busy      = (left_q != 3'd0);
  assign finishing = (left_q == 3'd1) && !out_stall_i;
  assign stall_o   = busy && !finishing;
  assign take      = valid_i && !stall_o;

  always_comb begin
    left_d = left_q;
    for (int j = 0; j < MaxChars; j++) begin
      chr_d[j] = chr_q[j];
    end
    if (take) begin
      left_d = cnt;
      for (int j = 0; j < MaxChars; j++) begin
        chr_d[j] = packed_chr[j];
      end
    end else if (busy && !out_stall_i) begin
      // advance to the next character
      left_d = left_q - 3'd1;
      for (int j = 0; j < MaxChars - 1; j++) begin
        chr_d[j] = chr_q[j+1];
      end
      chr_d[MaxChars-1] = CharZero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 3'd0;
    end else begin
      left_q <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MaxChars; j++) begin
      chr_q[j] <= chr_d[j];
    end
  end

  assign out_valid_o = busy;
  assign character_o = chr_q[0];
  assign last_o      = (left_q == 3'd1);

endmodule

// File: hw/rtl/fixed_point_decimal_formatter.sv
// Top level of the fixed-point decimal formatter: register file, pipeline, serializer.
// Depends on fpdf_pkg, fpdf_cfg, fpdf_front, fpdf_digit and fpdf_serial.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+---------------------
//   in       | input     | in_valid_i / in_stall_o | value_i
//   out      | output    | out_valid_o/out_stall_i | character_o, last_o
//   config   | input     | APB psel/penable/pready | paddr, pwdata, prdata
//
// A request passes five register stages (magnitude, then one stage per digit
// weight 10000/1000/100/10) and then the serializer, which registers its
// characters for the output. Each request leaves as 1 to 7 characters, one
// per cycle while the output is not stalled, so the character count of the
// request sets its throughput. Reset empties the pipeline and loads the
// register defaults. A stall on the output holds the current character and
// backs up the pipeline stage by stage; nothing is lost.
module fixed_point_decimal_formatter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [6:0]         character_o,
  output logic               last_o
);
  import fpdf_pkg::*;

  fpdf_cfg_t  cfg;
  logic       valid [NumStages+1];
  logic       stall [NumStages+1];
  fpdf_item_t item  [NumStages+1];

  fpdf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fpdf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .value_i (value_i),
    .valid_o (valid[0]),
    .stall_i (stall[0]),
    .item_o  (item[0])
  );

  for (genvar s = 0; s < NumStages; s++) begin : g_digit
    fpdf_digit u_digit (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (2'(s)),
      .valid_i (valid[s]),
      .stall_o (stall[s]),
      .item_i  (item[s]),
      .valid_o (valid[s+1]),
      .stall_i (stall[s+1]),
      .item_o  (item[s+1])
    );
  end

  fpdf_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid[NumStages]),
    .stall_o     (stall[NumStages]),
    .item_i      (item[NumStages]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

// File: dv/tb_fixed_point_decimal_formatter.sv
// Self-checking testbench for fixed_point_decimal_formatter: predicts the ASCII text of each value
// and compares every character and its last flag. Depends on fpdf_pkg and the formatter RTL only.
module tb_fixed_point_decimal_formatter;
  import fpdf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] RegUnused  = 2'd3;
  localparam int         CycleLimit = 400000;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } text_char_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [3:0]         paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] value_i     = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [6:0]         character_o;
  logic               last_o;

  // formatter settings as the block should hold them
  logic               sign_cfg;
  logic [2:0]         point_cfg;
  logic [3:0]         min_digits_cfg;

  text_char_t         pending_text[$];
  int                 idle_pct;
  int                 stall_pct;
  int                 error_count;
  int                 values_sent;
  int                 chars_checked;
  int                 cycle_count;

  fixed_point_decimal_formatter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d characters outstanding", cycle_count,
               pending_text.size());
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Build the expected text of one value under the current settings.
  function automatic void predict_text(input logic signed [15:0] v);
    logic        neg;
    int unsigned mag;
    int unsigned pt;
    int unsigned min_n;
    int unsigned own;
    int unsigned n;
    int unsigned weight;
    int unsigned digs[NumDigits];
    logic [6:0]  txt[$];
    text_char_t  c;
    neg    = v[15];
    mag    = neg ? unsigned'(-int'(v)) : unsigned'(int'(v));
    pt     = (point_cfg > MaxPoint) ? MaxPoint : point_cfg;
    min_n  = (min_digits_cfg > MaxMinDigits) ? MaxMinDigits : min_digits_cfg;
    weight = 10000;
    own    = 1;
    for (int i = 0; i < NumDigits; i++) begin
      digs[i] = (mag / weight) % 10;
      if (mag >= weight && own < NumDigits - i) own = NumDigits - i;
      weight = weight / 10;
    end
    n = own;
    if (min_n > n) n = min_n;
    if (pt != 0 && pt + 1 > n) n = pt + 1;
    if (n > NumDigits) n = NumDigits;
    if (sign_cfg) txt.push_back(neg ? CharMinus : CharPlus);
    for (int unsigned i = 0; i < n; i++) begin
      if (pt != 0 && i == n - pt) txt.push_back(CharPoint);
      txt.push_back(CharZero + 7'(digs[NumDigits - n + i]));
    end
    foreach (txt[i]) begin
      c.character = txt[i];
      c.last      = (i == txt.size() - 1);
      pending_text.push_back(c);
    end
  endfunction

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      chars_checked <= chars_checked + 1;
      if (pending_text.size() == 0) begin
        $error("unexpected character 0x%02h last=%0b", character_o, last_o);
        error_count++;
      end else begin
        want = pending_text.pop_front();
        if (character_o !== want.character) begin
          $error("character: expected 0x%02h, got 0x%02h", want.character, character_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          error_count++;
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegShowSign:      sign_cfg       = data[0];
      RegPointPosition: point_cfg      = data[2:0];
      RegMinDigits:     min_digits_cfg = data[3:0];
      default: ;
    endcase
  endtask

  task automatic set_format(input logic sign, input logic [2:0] pt, input logic [3:0] min_n);
    write_reg(RegShowSign, 32'(sign));
    write_reg(RegPointPosition, 32'(pt));
    write_reg(RegMinDigits, 32'(min_n));
  endtask

  // Offer one value; valid stays high after acceptance unless a gap follows.
  task automatic send_value(input logic signed [15:0] v);
    int gap;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_text(v);
    values_sent++;
  endtask

  // Drop valid and wait until every predicted character has come out.
  task automatic drain_stream();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_text.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_value();
    int unsigned pow;
    int          v;
    case ($urandom_range(3))
      0, 1: v = int'($signed(16'($urandom())));
      2:    v = $urandom_range(120);
      default: begin
        pow = 10 ** $urandom_range(4);
        v   = int'(pow) + $urandom_range(2) - 1;
      end
    endcase
    if ($urandom_range(1)) v = -v;
    return 16'(v);
  endfunction

  task automatic test_reset_format();
    send_value(16'sd0);
    send_value(16'sd7);
    send_value(-16'sd1);
    send_value(16'sd32767);
    send_value(-16'sd32768);
    drain_stream();
  endtask

  task automatic test_point_and_padding();
    // value below one gets a leading zero before the point
    set_format(1'b1, 3'd2, 4'd0);
    send_value(16'sd5);
    send_value(16'sd0);
    send_value(-16'sd32768);
    send_value(16'sd12345);
    drain_stream();
    // oversized point and minimum act as the largest legal ones
    set_format(1'b1, 3'd7, 4'd15);
    send_value(16'sd0);
    send_value(-16'sd1);
    send_value(16'sd32767);
    drain_stream();
    // zero with no minimum still writes one digit
    set_format(1'b0, 3'd0, 4'd0);
    send_value(16'sd0);
    send_value(16'sd10);
    drain_stream();
    set_format(1'b0, 3'd4, 4'd3);
    send_value(16'sd7);
    send_value(16'sd9999);
    send_value(-16'sd10000);
    drain_stream();
    set_format(1'b1, 3'd1, 4'd5);
    send_value(16'sd0);
    send_value(-16'sd99);
    drain_stream();
  endtask

  task automatic test_unused_register();
    write_reg(RegUnused, 32'hFFFF_FFFF);
    send_value(16'sd42);
    send_value(-16'sd300);
    drain_stream();
  endtask

  task automatic test_random_traffic();
    int idle_mix[4]  = '{0, 78, 0, 36};
    int stall_mix[4] = '{0, 0, 78, 36};
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = 0;
      stall_pct = 0;
      case (ph)
        0: set_format(1'b1, 3'd0, 4'd0);
        1: set_format(1'b0, 3'd4, 4'd5);
        default: set_format(1'($urandom_range(1)), 3'($urandom_range(7)),
                            4'($urandom_range(15)));
      endcase
      idle_pct  = idle_mix[ph];
      stall_pct = stall_mix[ph];
      repeat (72) send_value(pick_value());
      drain_stream();
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    sign_cfg       = 1'b0;
    point_cfg      = 3'd0;
    min_digits_cfg = 4'd1;
    idle_pct       = 0;
    stall_pct      = 0;
    error_count    = 0;
    values_sent    = 0;
    chars_checked  = 0;
    cycle_count    = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_format();
    test_point_and_padding();
    test_unused_register();
    test_random_traffic();

    if (pending_text.size() != 0) begin
      $error("%0d predicted characters never came out", pending_text.size());
      error_count++;
    end
    $display("formatted %0d values into %0d characters under directed and random settings",
             values_sent, chars_checked);
    $display("handshake mixes: free flow, sparse input, heavy output stall, both throttled");
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
